FILE: rtl/core/edgmag_pkg.sv
package edgmag_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COEF_BITS  = 5;

   localparam int PIX_W  = 8;
   localparam int DIM_W  = 11;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int POS_W  = 10;
   localparam int KER_W  = 9 * COEF_BITS;
   localparam int PROD_W = PIX_W + 1 + COEF_BITS;
   localparam int ACC_W  = PROD_W + 4;
   localparam int SUM_W  = 2 * ACC_W - 2;
   localparam int TAP_W  = 4;
   localparam int BIT_W  = 3;

   localparam logic [1:0] REG_KERNEL_X     = 2'd0;
   localparam logic [1:0] REG_KERNEL_Y     = 2'd1;
   localparam logic [1:0] REG_FRAME_WIDTH  = 2'd2;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

   typedef logic [PIX_W-1:0] pix_type;

   typedef struct packed {
      logic          done;
      logic [PIX_W-1:0] magnitude;
   } grad_res_type;

endpackage

FILE: rtl/core/edgmag_grad.sv
module edgmag_grad (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  edgmag_pkg::pix_type         win [9],
   input  logic [edgmag_pkg::KER_W-1:0] kernel_x,
   input  logic [edgmag_pkg::KER_W-1:0] kernel_y,
   output edgmag_pkg::grad_res_type    res
);

   typedef enum logic [2:0] {G_IDLE, G_MAC, G_SQX, G_SQY, G_ROOT} gstate_type;

   gstate_type state_ff;
   logic [edgmag_pkg::TAP_W-1:0]               k_ff;
   logic [edgmag_pkg::BIT_W-1:0]               bit_ff;
   logic signed [edgmag_pkg::ACC_W-1:0]        acc_x_ff;
   logic signed [edgmag_pkg::ACC_W-1:0]        acc_y_ff;
   logic [edgmag_pkg::SUM_W-1:0]               square_ff;
   logic [edgmag_pkg::SUM_W-1:0]               sum_ff;
   logic [edgmag_pkg::PIX_W-1:0]               root_ff;
   logic                                       done_ff;

   logic signed [edgmag_pkg::COEF_BITS-1:0]    coef_x;
   logic signed [edgmag_pkg::COEF_BITS-1:0]    coef_y;
   logic signed [edgmag_pkg::PROD_W-1:0]       prod_x;
   logic signed [edgmag_pkg::PROD_W-1:0]       prod_y;
   logic signed [edgmag_pkg::ACC_W-1:0]        acc_sel;
   logic signed [2*edgmag_pkg::ACC_W-1:0]      sq_full;
   logic [edgmag_pkg::PIX_W-1:0]               trial;
   logic [2*edgmag_pkg::PIX_W-1:0]             trial_sq;
   logic                                       root_last;

   always_comb begin
      coef_x    = kernel_x[k_ff*edgmag_pkg::COEF_BITS +: edgmag_pkg::COEF_BITS];
      coef_y    = kernel_y[k_ff*edgmag_pkg::COEF_BITS +: edgmag_pkg::COEF_BITS];
      prod_x    = $signed({1'b0, win[k_ff]}) * coef_x;
      prod_y    = $signed({1'b0, win[k_ff]}) * coef_y;
      acc_sel   = (state_ff == G_SQX) ? acc_x_ff : acc_y_ff;
      sq_full   = acc_sel * acc_sel;
      trial     = root_ff | (edgmag_pkg::PIX_W'(1) << bit_ff);
      trial_sq  = trial * trial;
      root_last = (sum_ff[edgmag_pkg::SUM_W-1:2*edgmag_pkg::PIX_W] != '0) || (bit_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == G_ROOT) && root_last;
         unique case (state_ff)
            G_IDLE: begin
               if (start) begin
                  k_ff     <= '0;
                  acc_x_ff <= '0;
                  acc_y_ff <= '0;
                  state_ff <= G_MAC;
               end
            end
            G_MAC: begin
               acc_x_ff <= acc_x_ff + edgmag_pkg::ACC_W'(prod_x);
               acc_y_ff <= acc_y_ff + edgmag_pkg::ACC_W'(prod_y);
               k_ff     <= k_ff + 1'b1;
               if (k_ff == edgmag_pkg::TAP_W'(8)) begin
                  state_ff <= G_SQX;
               end
            end
            G_SQX: begin
               square_ff <= sq_full[edgmag_pkg::SUM_W-1:0];
               state_ff  <= G_SQY;
            end
            G_SQY: begin
               sum_ff   <= square_ff + sq_full[edgmag_pkg::SUM_W-1:0];
               root_ff  <= '0;
               bit_ff   <= '1;
               state_ff <= G_ROOT;
            end
            G_ROOT: begin
               if (sum_ff[edgmag_pkg::SUM_W-1:2*edgmag_pkg::PIX_W] != '0) begin
                  root_ff  <= '1;
                  state_ff <= G_IDLE;
               end else begin
                  if (trial_sq <= sum_ff[2*edgmag_pkg::PIX_W-1:0]) begin
                     root_ff <= trial;
                  end
                  bit_ff <= bit_ff - 1'b1;
                  if (bit_ff == '0) begin
                     state_ff <= G_IDLE;
                  end
               end
            end
            default: state_ff <= G_IDLE;
         endcase
      end
   end

   assign res.done      = done_ff;
   assign res.magnitude = root_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == G_IDLE)
      else $error("gradient start while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("gradient done longer than one cycle");
   a_mac_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == G_MAC |-> k_ff <= edgmag_pkg::TAP_W'(8))
      else $error("tap index out of window");
`endif

endmodule

FILE: rtl/core/edge_magnitude_3x3.sv
// channel   dir  handshake                  payload
// req       in   req_tvalid / req_tready    tdata[7:0] pixel
// rsp       out  rsp_tvalid / rsp_tready    tdata magnitude,row,col; tlast frame end
// csr       in   psel, penable, pwrite      64-bit registers at 8*index
// a border pixel reads the line memory when it is taken and writes it back in S_READ
// an interior pixel then runs a 9-step shared multiply-accumulate over the
// window, two shared squaring steps and an 8-step bitwise root (1 step when saturated)
// synchronous reset clears counters, window, kernels and sets a 640 x 480 frame
// the line memory is not cleared; the result register holds while rsp_tready is low,
// and the next pixel may be taken while a result waits there
module edge_magnitude_3x3 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] magnitude, [17:8] center_row, [27:18] center_col
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC, S_OUT} state_type;

   localparam int LW = 2 * edgmag_pkg::PIX_W;

   state_type state_ff;

   logic [edgmag_pkg::KER_W-1:0] kernel_x_ff;
   logic [edgmag_pkg::KER_W-1:0] kernel_y_ff;
   logic [edgmag_pkg::DIM_W-1:0] width_ff;
   logic [edgmag_pkg::DIM_W-1:0] height_ff;

   logic [LW-1:0] line_mem_ff [edgmag_pkg::MAX_WIDTH];
   logic [LW-1:0] rd_ff;

   edgmag_pkg::pix_type win_ff [9];

   logic [edgmag_pkg::COL_W-1:0] col_ff;
   logic [edgmag_pkg::ROW_W-1:0] row_ff;
   logic [edgmag_pkg::COL_W-1:0] addr_ff;
   logic [edgmag_pkg::PIX_W-1:0] px_ff;
   logic                         emit_ff;
   logic [edgmag_pkg::POS_W-1:0] crow_ff;
   logic [edgmag_pkg::POS_W-1:0] ccol_ff;
   logic                         last_ff;

   logic                         rsp_valid_ff;
   logic [edgmag_pkg::PIX_W-1:0] rsp_mag_ff;
   logic [edgmag_pkg::POS_W-1:0] rsp_row_ff;
   logic [edgmag_pkg::POS_W-1:0] rsp_col_ff;
   logic                         rsp_last_ff;

   logic [edgmag_pkg::DIM_W-1:0] w_eff;
   logic [edgmag_pkg::DIM_W-1:0] h_eff;
   logic [edgmag_pkg::DIM_W-1:0] col_ext;
   logic [edgmag_pkg::DIM_W-1:0] row_ext;
   logic [edgmag_pkg::DIM_W-1:0] col_plus;
   logic [edgmag_pkg::DIM_W-1:0] row_plus;
   logic [edgmag_pkg::COL_W-1:0] col_in;
   logic [edgmag_pkg::ROW_W-1:0] row_in;
   logic                         emit_in;
   logic                         last_in;
   logic                         req_fire;
   logic                         cfg_wr;
   logic                         grad_start;
   logic                         out_load;
   edgmag_pkg::grad_res_type     grad_res;

   always_comb begin
      if (width_ff < edgmag_pkg::DIM_W'(3)) begin
         w_eff = edgmag_pkg::DIM_W'(3);
      end else if (width_ff > edgmag_pkg::DIM_W'(edgmag_pkg::MAX_WIDTH)) begin
         w_eff = edgmag_pkg::DIM_W'(edgmag_pkg::MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff < edgmag_pkg::DIM_W'(3)) begin
         h_eff = edgmag_pkg::DIM_W'(3);
      end else if (height_ff > edgmag_pkg::DIM_W'(edgmag_pkg::MAX_HEIGHT)) begin
         h_eff = edgmag_pkg::DIM_W'(edgmag_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      col_ext  = edgmag_pkg::DIM_W'(col_ff);
      row_ext  = edgmag_pkg::DIM_W'(row_ff);
      col_plus = col_ext + 1'b1;
      row_plus = row_ext + 1'b1;
      col_in   = col_plus[edgmag_pkg::COL_W-1:0];
      row_in   = row_ff;
      if (col_plus >= w_eff) begin
         col_in = '0;
         row_in = row_plus[edgmag_pkg::ROW_W-1:0];
         if (row_plus >= h_eff) begin
            row_in = '0;
         end
      end
      emit_in = (row_ext >= edgmag_pkg::DIM_W'(2)) && (col_ext >= edgmag_pkg::DIM_W'(2)) &&
                (row_ext < h_eff) && (col_ext < w_eff);
      last_in = (row_ext == h_eff - 1'b1) && (col_ext == w_eff - 1'b1);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign grad_start = (state_ff == S_READ) && emit_ff;
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[4:3])
         edgmag_pkg::REG_KERNEL_X:     csr_prdata = 64'(kernel_x_ff);
         edgmag_pkg::REG_KERNEL_Y:     csr_prdata = 64'(kernel_y_ff);
         edgmag_pkg::REG_FRAME_WIDTH:  csr_prdata = 64'(width_ff);
         edgmag_pkg::REG_FRAME_HEIGHT: csr_prdata = 64'(height_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_x_ff <= '0;
         kernel_y_ff <= '0;
         width_ff    <= edgmag_pkg::DIM_W'(640);
         height_ff   <= edgmag_pkg::DIM_W'(480);
      end else if (cfg_wr) begin
         unique case (csr_paddr[4:3])
            edgmag_pkg::REG_KERNEL_X:     kernel_x_ff <= csr_pwdata[edgmag_pkg::KER_W-1:0];
            edgmag_pkg::REG_KERNEL_Y:     kernel_y_ff <= csr_pwdata[edgmag_pkg::KER_W-1:0];
            edgmag_pkg::REG_FRAME_WIDTH:  width_ff    <= csr_pwdata[edgmag_pkg::DIM_W-1:0];
            edgmag_pkg::REG_FRAME_HEIGHT: height_ff   <= csr_pwdata[edgmag_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // line memory: upper row in the high byte, middle row in the low byte
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= line_mem_ff[col_ff];
      end
      if (state_ff == S_READ) begin
         line_mem_ff[addr_ff] <= {rd_ff[edgmag_pkg::PIX_W-1:0], px_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  px_ff    <= req_tdata;
                  addr_ff  <= col_ff;
                  emit_ff  <= emit_in;
                  last_ff  <= last_in;
                  crow_ff  <= edgmag_pkg::POS_W'(row_ff - 1'b1);
                  ccol_ff  <= edgmag_pkg::POS_W'(col_ff - 1'b1);
                  col_ff   <= col_in;
                  row_ff   <= row_in;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               for (int i = 0; i < 3; i++) begin
                  win_ff[3*i]   <= win_ff[3*i+1];
                  win_ff[3*i+1] <= win_ff[3*i+2];
               end
               win_ff[2] <= rd_ff[LW-1:edgmag_pkg::PIX_W];
               win_ff[5] <= rd_ff[edgmag_pkg::PIX_W-1:0];
               win_ff[8] <= px_ff;
               state_ff  <= emit_ff ? S_CALC : S_IDLE;
            end
            S_CALC: begin
               if (grad_res.done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_load) begin
                  rsp_mag_ff   <= grad_res.magnitude;
                  rsp_row_ff   <= crow_ff;
                  rsp_col_ff   <= ccol_ff;
                  rsp_last_ff  <= last_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   edgmag_grad u_grad (
      .clock    (clock),
      .reset    (reset),
      .start    (grad_start),
      .win      (win_ff),
      .kernel_x (kernel_x_ff),
      .kernel_y (kernel_y_ff),
      .res      (grad_res)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_col_ff, rsp_row_ff, rsp_mag_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("pixel accepted before line memory write back");
   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      grad_res.done |-> state_ff == S_CALC)
      else $error("gradient result outside calc state");
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_row_ff != '0) && (rsp_col_ff != '0))
      else $error("border position in result");
   a_out_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) && rsp_valid_ff && !rsp_tready |=> state_ff == S_OUT)
      else $error("result dropped while output stalled");
`endif

endmodule
